@@ rtl/mbc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mbc_pkg
// Shared types, constants and helper functions of the backtracking maze carver.
// ----------------------------------------------------------------------------
package mbc_pkg;

   localparam int MAX_SIDE    = 64;
   localparam int STACK_DEPTH = 1024;

   localparam int COORD_W    = $clog2(MAX_SIDE);
   localparam int CFG_SIZE_W = 7;                       // fixed register width
   localparam int PROD_W     = COORD_W + CFG_SIZE_W;
   localparam int TC_W       = COORD_W + 2;             // signed target coordinate
   localparam int GRID_DEPTH = MAX_SIDE * MAX_SIDE;
   localparam int GRID_AW    = $clog2(GRID_DEPTH);
   localparam int STACK_AW   = $clog2(STACK_DEPTH);
   localparam int COUNT_W    = $clog2(STACK_DEPTH + 1);
   localparam int EPOCH_W    = 8;
   localparam int PICKS_W    = 8;
   localparam int NEXT_W     = 3;
   localparam int CSR_AW     = 3;
   localparam int CSR_DW     = 32;

   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
   localparam logic [EPOCH_W-1:0] EPOCH_MAX   = {EPOCH_W{1'b1}};
   localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;
   localparam logic [GRID_AW-1:0] GRID_LAST   = GRID_AW'(GRID_DEPTH - 1);

   localparam logic [CFG_SIZE_W-1:0] SIZE_RESET = CFG_SIZE_W'(63);

   // register indexes (byte address / 4)
   localparam logic REG_FIELD_WIDTH  = 1'b0;
   localparam logic REG_FIELD_HEIGHT = 1'b1;

   localparam logic KIND_START   = 1'b0;
   localparam logic KIND_ADVANCE = 1'b1;

   typedef enum logic [1:0] {
      DIR_UP,
      DIR_DOWN,
      DIR_LEFT,
      DIR_RIGHT
   } dir_type;

   typedef logic [3:0][1:0] dir_order_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      dir_order_type      order;
      logic [NEXT_W-1:0]  next;
   } stack_entry_type;

   typedef struct packed {
      logic [CFG_SIZE_W-1:0] field_width;
      logic [CFG_SIZE_W-1:0] field_height;
   } cfg_type;

   typedef struct packed {
      logic               we;
      logic [GRID_AW-1:0] addr;
      logic [EPOCH_W-1:0] wdata;
   } grid_req_type;

   typedef struct packed {
      logic                we;
      logic [STACK_AW-1:0] addr;
      stack_entry_type     wdata;
   } stack_req_type;

   typedef struct packed {
      logic [COORD_W-1:0] cell_x;
      logic [COORD_W-1:0] cell_y;
      logic [COORD_W-1:0] wall_x;
      logic [COORD_W-1:0] wall_y;
      logic               is_start;
      logic               done_res;
   } result_type;

   typedef struct packed {
      logic               clearing;
      logic [COUNT_W-1:0] stack_count;
   } status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_START_IDX,
      ST_START_WR,
      ST_POP_RD,
      ST_POP_EVAL,
      ST_TGT_IDX,
      ST_TGT_RD,
      ST_TGT_CHK,
      ST_WALL_WR,
      ST_EMIT
   } walk_state_type;

   // four swaps, order[i] <-> order[pick i]
   function automatic dir_order_type shuffle_dirs(input logic [PICKS_W-1:0] picks);
      dir_order_type ord;
      logic [1:0]    tmp;
      logic [1:0]    r;
      ord[0] = DIR_UP;
      ord[1] = DIR_DOWN;
      ord[2] = DIR_LEFT;
      ord[3] = DIR_RIGHT;
      for (int i = 0; i < 4; i++) begin
         r      = picks[2*i +: 2];
         tmp    = ord[r];
         ord[r] = ord[i];
         ord[i] = tmp;
      end
      return ord;
   endfunction

   // row-major cell address, y * width + x
   function automatic logic [GRID_AW-1:0] cell_index(input logic [COORD_W-1:0] x,
                                                      input logic [COORD_W-1:0] y,
                                                      input logic [CFG_SIZE_W-1:0] w);
      logic [PROD_W-1:0] p;
      p = PROD_W'(y) * PROD_W'(w) + PROD_W'(x);
      return p[GRID_AW-1:0];
   endfunction

endpackage
`default_nettype wire

@@ rtl/mbc_csr.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mbc_csr
// APB-style register block holding the field width and height.
// ----------------------------------------------------------------------------
module mbc_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [mbc_pkg::CSR_AW-1:0]    csr_paddr,
   input  wire logic [mbc_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic      [mbc_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                               csr_pready,
   output mbc_pkg::cfg_type                   cfg
);

   logic [mbc_pkg::CFG_SIZE_W-1:0] width_ff,  width_in;
   logic [mbc_pkg::CFG_SIZE_W-1:0] height_ff, height_in;
   logic                           wr_en;
   logic                           reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (wr_en) begin
         case (reg_idx)
            mbc_pkg::REG_FIELD_WIDTH:  width_in  = csr_pwdata[mbc_pkg::CFG_SIZE_W-1:0];
            mbc_pkg::REG_FIELD_HEIGHT: height_in = csr_pwdata[mbc_pkg::CFG_SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         mbc_pkg::REG_FIELD_WIDTH:  csr_prdata = mbc_pkg::CSR_DW'(width_ff);
         mbc_pkg::REG_FIELD_HEIGHT: csr_prdata = mbc_pkg::CSR_DW'(height_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= mbc_pkg::SIZE_RESET;
         height_ff <= mbc_pkg::SIZE_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign cfg.field_width  = width_ff;
   assign cfg.field_height = height_ff;

endmodule
`default_nettype wire

@@ rtl/mbc_grid_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mbc_grid_ram
// Single-port grid store, one epoch tag per cell. A cell is open when its tag
// matches the current epoch. Registered read.
// ----------------------------------------------------------------------------
module mbc_grid_ram (
   input  wire logic                          clock,
   input  wire mbc_pkg::grid_req_type         grid_req,
   output logic      [mbc_pkg::EPOCH_W-1:0]   grid_rdata
);

   logic [mbc_pkg::EPOCH_W-1:0] grid_mem [mbc_pkg::GRID_DEPTH];
   logic [mbc_pkg::EPOCH_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (grid_req.we) begin
         grid_mem[grid_req.addr] <= grid_req.wdata;
      end
      rdata_ff <= grid_mem[grid_req.addr];
   end

   assign grid_rdata = rdata_ff;

endmodule
`default_nettype wire

@@ rtl/mbc_stack_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mbc_stack_ram
// Single-port walk stack: cell, shuffled direction order, next direction.
// Registered read.
// ----------------------------------------------------------------------------
module mbc_stack_ram (
   input  wire logic                     clock,
   input  wire mbc_pkg::stack_req_type   stack_req,
   output mbc_pkg::stack_entry_type      stack_rdata
);

   mbc_pkg::stack_entry_type stack_mem [mbc_pkg::STACK_DEPTH];
   mbc_pkg::stack_entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (stack_req.we) begin
         stack_mem[stack_req.addr] <= stack_req.wdata;
      end
      rdata_ff <= stack_mem[stack_req.addr];
   end

   assign stack_rdata = rdata_ff;

endmodule
`default_nettype wire

@@ rtl/mbc_walk_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mbc_walk_ctrl
// Carving sequencer: pops exhausted stack entries, probes the next direction
// of the top cell, opens target and wall cells and pushes the target.
// ----------------------------------------------------------------------------
module mbc_walk_ctrl (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_kind,
   input  wire logic [mbc_pkg::PICKS_W-1:0]       req_random_picks,
   input  wire logic [mbc_pkg::COORD_W-1:0]       req_start_x,
   input  wire logic [mbc_pkg::COORD_W-1:0]       req_start_y,
   input  wire mbc_pkg::cfg_type                  cfg,
   output mbc_pkg::grid_req_type                  grid_req,
   input  wire logic [mbc_pkg::EPOCH_W-1:0]       grid_rdata,
   output mbc_pkg::stack_req_type                 stack_req,
   input  wire mbc_pkg::stack_entry_type          stack_rdata,
   output logic                                   res_valid,
   output mbc_pkg::result_type                    res,
   input  wire logic                              res_take,
   output mbc_pkg::status_type                    status
);

   mbc_pkg::walk_state_type          state_ff, state_in;
   logic [mbc_pkg::COUNT_W-1:0]      count_ff, count_in;
   logic [mbc_pkg::EPOCH_W-1:0]      epoch_ff, epoch_in;
   logic [mbc_pkg::GRID_AW-1:0]      clr_addr_ff, clr_addr_in;
   logic                             start_pend_ff, start_pend_in;
   logic [mbc_pkg::PICKS_W-1:0]      picks_ff, picks_in;
   logic [mbc_pkg::COORD_W-1:0]      tx_ff, tx_in, ty_ff, ty_in;
   logic [mbc_pkg::COORD_W-1:0]      wx_ff, wx_in, wy_ff, wy_in;
   logic [mbc_pkg::GRID_AW-1:0]      tidx_ff, tidx_in, widx_ff, widx_in;
   mbc_pkg::result_type              res_ff, res_in;

   logic [mbc_pkg::CFG_SIZE_W-1:0]   eff_w, eff_h;
   logic                             accept;
   logic                             start_in_field;
   logic                             tgt_in_field;
   logic                             tgt_open;
   logic                             stack_full;
   logic [mbc_pkg::COUNT_W-1:0]      top_idx;
   logic [mbc_pkg::COORD_W-1:0]      idx_x, idx_y;
   logic [mbc_pkg::GRID_AW-1:0]      idx_val;
   logic signed [mbc_pkg::TC_W-1:0]  txs, tys, wxs, wys;
   mbc_pkg::stack_entry_type         wb_entry;
   mbc_pkg::stack_entry_type         push_entry;

   assign eff_w = (cfg.field_width > mbc_pkg::CFG_SIZE_W'(mbc_pkg::MAX_SIDE)) ?
                  mbc_pkg::CFG_SIZE_W'(mbc_pkg::MAX_SIDE) : cfg.field_width;
   assign eff_h = (cfg.field_height > mbc_pkg::CFG_SIZE_W'(mbc_pkg::MAX_SIDE)) ?
                  mbc_pkg::CFG_SIZE_W'(mbc_pkg::MAX_SIDE) : cfg.field_height;

   assign accept         = (state_ff == mbc_pkg::ST_IDLE) && req_valid;
   assign start_in_field = (mbc_pkg::CFG_SIZE_W'(tx_ff) < eff_w) &&
                           (mbc_pkg::CFG_SIZE_W'(ty_ff) < eff_h);
   assign tgt_open       = (grid_rdata == epoch_ff);
   assign stack_full     = (count_ff >= mbc_pkg::COUNT_W'(mbc_pkg::STACK_DEPTH));
   assign top_idx        = count_ff - mbc_pkg::COUNT_W'(1);

   // one shared index multiplier
   always_comb begin
      if (state_ff == mbc_pkg::ST_TGT_RD) begin
         idx_x = wx_ff;
         idx_y = wy_ff;
      end else begin
         idx_x = tx_ff;
         idx_y = ty_ff;
      end
      idx_val = mbc_pkg::cell_index(idx_x, idx_y, eff_w);
   end

   // target and wall of the top entry's next direction
   always_comb begin
      txs = mbc_pkg::TC_W'(stack_rdata.x);
      tys = mbc_pkg::TC_W'(stack_rdata.y);
      wxs = txs;
      wys = tys;
      case (mbc_pkg::dir_type'(stack_rdata.order[stack_rdata.next[1:0]]))
         mbc_pkg::DIR_UP: begin
            tys = tys - mbc_pkg::TC_W'(2);
            wys = wys - mbc_pkg::TC_W'(1);
         end
         mbc_pkg::DIR_DOWN: begin
            tys = tys + mbc_pkg::TC_W'(2);
            wys = wys + mbc_pkg::TC_W'(1);
         end
         mbc_pkg::DIR_LEFT: begin
            txs = txs - mbc_pkg::TC_W'(2);
            wxs = wxs - mbc_pkg::TC_W'(1);
         end
         default: begin
            txs = txs + mbc_pkg::TC_W'(2);
            wxs = wxs + mbc_pkg::TC_W'(1);
         end
      endcase
      tgt_in_field = !txs[mbc_pkg::TC_W-1] && !tys[mbc_pkg::TC_W-1] &&
                     (txs < mbc_pkg::TC_W'(eff_w)) && (tys < mbc_pkg::TC_W'(eff_h));
      wb_entry      = stack_rdata;
      wb_entry.next = stack_rdata.next + mbc_pkg::NEXT_W'(1);
   end

   always_comb begin
      push_entry.x     = tx_ff;
      push_entry.y     = ty_ff;
      push_entry.order = mbc_pkg::shuffle_dirs(picks_ff);
      push_entry.next  = '0;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mbc_pkg::ST_CLEAR: begin
            if (clr_addr_ff == mbc_pkg::GRID_LAST) begin
               state_in = start_pend_ff ? mbc_pkg::ST_START_IDX : mbc_pkg::ST_IDLE;
            end
         end
         mbc_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_kind == mbc_pkg::KIND_START) begin
                  state_in = (epoch_ff == mbc_pkg::EPOCH_MAX) ? mbc_pkg::ST_CLEAR :
                                                                mbc_pkg::ST_START_IDX;
               end else begin
                  state_in = mbc_pkg::ST_POP_RD;
               end
            end
         end
         mbc_pkg::ST_START_IDX:
            state_in = start_in_field ? mbc_pkg::ST_START_WR : mbc_pkg::ST_EMIT;
         mbc_pkg::ST_START_WR:  state_in = mbc_pkg::ST_EMIT;
         mbc_pkg::ST_POP_RD:
            state_in = (count_ff == '0) ? mbc_pkg::ST_EMIT : mbc_pkg::ST_POP_EVAL;
         mbc_pkg::ST_POP_EVAL: begin
            if (!stack_rdata.next[2] && tgt_in_field) begin
               state_in = mbc_pkg::ST_TGT_IDX;
            end else begin
               state_in = mbc_pkg::ST_POP_RD;
            end
         end
         mbc_pkg::ST_TGT_IDX:   state_in = mbc_pkg::ST_TGT_RD;
         mbc_pkg::ST_TGT_RD:    state_in = mbc_pkg::ST_TGT_CHK;
         mbc_pkg::ST_TGT_CHK:
            state_in = tgt_open ? mbc_pkg::ST_POP_RD : mbc_pkg::ST_WALL_WR;
         mbc_pkg::ST_WALL_WR:   state_in = mbc_pkg::ST_EMIT;
         mbc_pkg::ST_EMIT:
            if (res_take) begin
               state_in = mbc_pkg::ST_IDLE;
            end
         default:               state_in = mbc_pkg::ST_IDLE;
      endcase
   end

   // datapath registers
   always_comb begin
      count_in      = count_ff;
      epoch_in      = epoch_ff;
      clr_addr_in   = clr_addr_ff;
      start_pend_in = start_pend_ff;
      picks_in      = picks_ff;
      tx_in         = tx_ff;
      ty_in         = ty_ff;
      wx_in         = wx_ff;
      wy_in         = wy_ff;
      tidx_in       = tidx_ff;
      widx_in       = widx_ff;
      res_in        = res_ff;
      case (state_ff)
         mbc_pkg::ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + mbc_pkg::GRID_AW'(1);
            if (clr_addr_ff == mbc_pkg::GRID_LAST) begin
               start_pend_in = 1'b0;
            end
         end
         mbc_pkg::ST_IDLE: begin
            if (accept) begin
               picks_in = req_random_picks;
               if (req_kind == mbc_pkg::KIND_START) begin
                  tx_in    = req_start_x;
                  ty_in    = req_start_y;
                  count_in = '0;
                  if (epoch_ff == mbc_pkg::EPOCH_MAX) begin
                     // tags about to alias: wipe the grid first
                     epoch_in      = mbc_pkg::EPOCH_FIRST;
                     clr_addr_in   = '0;
                     start_pend_in = 1'b1;
                  end else begin
                     epoch_in = epoch_ff + mbc_pkg::EPOCH_W'(1);
                  end
               end
            end
         end
         mbc_pkg::ST_START_IDX: begin
            tidx_in         = idx_val;
            res_in.cell_x   = tx_ff;
            res_in.cell_y   = ty_ff;
            res_in.wall_x   = '0;
            res_in.wall_y   = '0;
            res_in.is_start = 1'b1;
            res_in.done_res = !start_in_field;
         end
         mbc_pkg::ST_START_WR: count_in = mbc_pkg::COUNT_W'(1);
         mbc_pkg::ST_POP_RD: begin
            if (count_ff == '0) begin
               res_in          = '0;
               res_in.done_res = 1'b1;
            end
         end
         mbc_pkg::ST_POP_EVAL: begin
            if (stack_rdata.next[2]) begin
               count_in = top_idx;
            end else begin
               tx_in = txs[mbc_pkg::COORD_W-1:0];
               ty_in = tys[mbc_pkg::COORD_W-1:0];
               wx_in = wxs[mbc_pkg::COORD_W-1:0];
               wy_in = wys[mbc_pkg::COORD_W-1:0];
            end
         end
         mbc_pkg::ST_TGT_IDX: tidx_in = idx_val;
         mbc_pkg::ST_TGT_RD:  widx_in = idx_val;
         mbc_pkg::ST_WALL_WR: begin
            if (!stack_full) begin
               count_in = count_ff + mbc_pkg::COUNT_W'(1);
            end
            res_in.cell_x   = tx_ff;
            res_in.cell_y   = ty_ff;
            res_in.wall_x   = wx_ff;
            res_in.wall_y   = wy_ff;
            res_in.is_start = 1'b0;
            res_in.done_res = 1'b0;
         end
         default: ;
      endcase
   end

   // memory ports and handshake
   always_comb begin
      req_stall       = (state_ff != mbc_pkg::ST_IDLE);
      res_valid       = (state_ff == mbc_pkg::ST_EMIT);
      grid_req.we     = 1'b0;
      grid_req.addr   = tidx_ff;
      grid_req.wdata  = epoch_ff;
      stack_req.we    = 1'b0;
      stack_req.addr  = top_idx[mbc_pkg::STACK_AW-1:0];
      stack_req.wdata = push_entry;
      case (state_ff)
         mbc_pkg::ST_CLEAR: begin
            grid_req.we    = 1'b1;
            grid_req.addr  = clr_addr_ff;
            grid_req.wdata = mbc_pkg::EPOCH_NONE;
         end
         mbc_pkg::ST_START_WR: begin
            grid_req.we    = 1'b1;
            stack_req.we   = 1'b1;
            stack_req.addr = '0;
         end
         mbc_pkg::ST_POP_EVAL: begin
            // written back before the next read is issued, so no forwarding path
            if (!stack_rdata.next[2]) begin
               stack_req.we    = 1'b1;
               stack_req.wdata = wb_entry;
            end
         end
         mbc_pkg::ST_TGT_CHK: grid_req.we = !tgt_open;
         mbc_pkg::ST_WALL_WR: begin
            grid_req.we    = 1'b1;
            grid_req.addr  = widx_ff;
            stack_req.we   = !stack_full;
            stack_req.addr = count_ff[mbc_pkg::STACK_AW-1:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mbc_pkg::ST_CLEAR;
         count_ff      <= '0;
         epoch_ff      <= mbc_pkg::EPOCH_FIRST;
         clr_addr_ff   <= '0;
         start_pend_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         epoch_ff      <= epoch_in;
         clr_addr_ff   <= clr_addr_in;
         start_pend_ff <= start_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      picks_ff <= picks_in;
      tx_ff    <= tx_in;
      ty_ff    <= ty_in;
      wx_ff    <= wx_in;
      wy_ff    <= wy_in;
      tidx_ff  <= tidx_in;
      widx_ff  <= widx_in;
      res_ff   <= res_in;
   end

   assign res                = res_ff;
   assign status.clearing    = (state_ff == mbc_pkg::ST_CLEAR);
   assign status.stack_count = count_ff;

endmodule
`default_nettype wire

@@ rtl/maze_backtracker_carver.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// maze_backtracker_carver
// Depth-first backtracking maze carver with grid and stack held in RAM.
// ----------------------------------------------------------------------------
// Each request transaction yields exactly one response transaction. A start
// places the start cell, or reports done when that cell lies outside the
// field. An advance pops exhausted entries, skips out-of-field directions
// and directions that hit an already open cell, carves the first direction
// that reaches an unopened cell, and reports done once the stack is empty.
// The pace is set by the single-port grid and stack RAMs, each visited once
// per cycle with a registered read. Grid cells carry an 8-bit epoch tag, so a
// start normally clears the maze without touching the RAM; after reset, and
// on every 255th start, a clearing pass over all 4096 cells runs during which
// requests are stalled. The response sits in an output register, so the next
// request is taken while a result still waits.
module maze_backtracker_carver (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic                             req_kind,
   input  wire logic [mbc_pkg::PICKS_W-1:0]      req_random_picks,
   input  wire logic [mbc_pkg::COORD_W-1:0]      req_start_x,
   input  wire logic [mbc_pkg::COORD_W-1:0]      req_start_y,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic      [mbc_pkg::COORD_W-1:0]      rsp_cell_x,
   output logic      [mbc_pkg::COORD_W-1:0]      rsp_cell_y,
   output logic      [mbc_pkg::COORD_W-1:0]      rsp_wall_x,
   output logic      [mbc_pkg::COORD_W-1:0]      rsp_wall_y,
   output logic                                  rsp_is_start,
   output logic                                  rsp_done_res,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [mbc_pkg::CSR_AW-1:0]       csr_paddr,
   input  wire logic [mbc_pkg::CSR_DW-1:0]       csr_pwdata,
   output logic      [mbc_pkg::CSR_DW-1:0]       csr_prdata,
   output logic                                  csr_pready
);

   mbc_pkg::cfg_type              cfg;
   mbc_pkg::grid_req_type         grid_req;
   logic [mbc_pkg::EPOCH_W-1:0]   grid_rdata;
   mbc_pkg::stack_req_type        stack_req;
   mbc_pkg::stack_entry_type      stack_rdata;
   mbc_pkg::result_type           res;
   mbc_pkg::status_type           status;
   logic                          res_valid;
   logic                          res_take;

   logic                          rsp_valid_ff, rsp_valid_in;
   mbc_pkg::result_type           rsp_ff, rsp_in;

   mbc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   mbc_grid_ram u_grid (
      .clock      (clock),
      .grid_req   (grid_req),
      .grid_rdata (grid_rdata)
   );

   mbc_stack_ram u_stack (
      .clock       (clock),
      .stack_req   (stack_req),
      .stack_rdata (stack_rdata)
   );

   mbc_walk_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_random_picks (req_random_picks),
      .req_start_x      (req_start_x),
      .req_start_y      (req_start_y),
      .cfg              (cfg),
      .grid_req         (grid_req),
      .grid_rdata       (grid_rdata),
      .stack_req        (stack_req),
      .stack_rdata      (stack_rdata),
      .res_valid        (res_valid),
      .res              (res),
      .res_take         (res_take),
      .status           (status)
   );

   // output register: loads when empty or being drained this cycle
   assign res_take = res_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (res_take) begin
         rsp_in       = res;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_cell_x   = rsp_ff.cell_x;
   assign rsp_cell_y   = rsp_ff.cell_y;
   assign rsp_wall_x   = rsp_ff.wall_x;
   assign rsp_wall_y   = rsp_ff.wall_y;
   assign rsp_is_start = rsp_ff.is_start;
   assign rsp_done_res = rsp_ff.done_res;

   // no request is taken while the grid is being wiped
   a_no_accept_while_clearing : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> !status.clearing)
      else $error("request accepted during grid clearing pass");

   // stack occupancy bounded by its depth
   a_stack_bound : assert property (@(posedge clock) disable iff (reset)
      status.stack_count <= mbc_pkg::COUNT_W'(mbc_pkg::STACK_DEPTH))
      else $error("stack count beyond depth");

   // a finished-maze answer to an advance carries no coordinates
   a_done_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_done_res && !rsp_is_start) |->
      (rsp_cell_x == '0 && rsp_cell_y == '0 && rsp_wall_x == '0 && rsp_wall_y == '0))
      else $error("done response with non-zero coordinates");

   // a loaded result is held until the response register frees up
   a_res_hold : assert property (@(posedge clock) disable iff (reset)
      (res_valid && !res_take) |=> res_valid && $stable(res))
      else $error("pending result changed before transfer");

endmodule
`default_nettype wire
